### src/idpr_pkg.sv
package idpr_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA  = 3'd0,
        CFG_BETA   = 3'd1,
        CFG_C_ZP   = 3'd2,
        CFG_SHIFT  = 3'd3,
        CFG_A_ZP   = 3'd4,
        CFG_B_ZP   = 3'd5,
        CFG_Y_ZP   = 3'd6,
        CFG_CLAMP  = 3'd7
    } t_cfg_idx;

    localparam logic [31:0] ALPHA_RST = 32'd1;
    localparam logic [15:0] CLAMP_RST = 16'h7F80;

    // datapath step selected by the controller
    typedef enum logic [2:0] {
        STEP_NONE  = 3'd0,
        STEP_ALPHA = 3'd1,
        STEP_BETA  = 3'd2,
        STEP_SUM   = 3'd3,
        STEP_RQ    = 3'd4,
        STEP_BIAS  = 3'd5,
        STEP_SHIFT = 3'd6,
        STEP_OUT   = 3'd7
    } t_step;

    typedef struct packed {
        logic  mac;
        logic  capture;
        t_step step;
    } t_dp_cmd;

endpackage

### src/idpr_ctrl.sv
module idpr_ctrl import idpr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_last_pair,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_ALPHA, S_BETA, S_SUM, S_RQ, S_BIAS, S_SHIFT, S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_accept;
    logic   w_load;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && o_in_ready;
    // output slot is free when empty or being drained this cycle
    assign w_load      = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state      = r_state;
        o_cmd.mac     = w_accept;
        o_cmd.capture = w_accept && i_last_pair;
        o_cmd.step    = STEP_NONE;
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_last_pair) n_state = S_ALPHA;
            end
            S_ALPHA: begin
                o_cmd.step = STEP_ALPHA;
                n_state    = S_BETA;
            end
            S_BETA: begin
                o_cmd.step = STEP_BETA;
                n_state    = S_SUM;
            end
            S_SUM: begin
                o_cmd.step = STEP_SUM;
                n_state    = S_RQ;
            end
            S_RQ: begin
                o_cmd.step = STEP_RQ;
                n_state    = S_BIAS;
            end
            S_BIAS: begin
                o_cmd.step = STEP_BIAS;
                n_state    = S_SHIFT;
            end
            S_SHIFT: begin
                o_cmd.step = STEP_SHIFT;
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (w_load) begin
                    o_cmd.step = STEP_OUT;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### src/idpr_datapath.sv
module idpr_datapath import idpr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_dp_cmd               i_cmd,
    input  logic signed [7:0]     i_a_elem,
    input  logic signed [7:0]     i_b_elem,
    input  logic signed [31:0]    i_c_elem,
    input  logic signed [31:0]    i_requant_mul,
    input  logic signed [31:0]    i_requant_add,
    output logic signed [7:0]     o_y_elem
);

    // configuration registers
    logic [31:0] r_alpha;
    logic [31:0] r_beta;
    logic [31:0] r_c_zp;
    logic [5:0]  r_shift_rnd;
    logic [8:0]  r_a_zp;
    logic [8:0]  r_b_zp;
    logic [31:0] r_y_zp;
    logic [15:0] r_clamp;

    // working registers
    logic [31:0] r_acc;
    logic [31:0] r_csum;
    logic [31:0] r_rq_mul;
    logic [31:0] r_rq_add;
    logic [31:0] r_prod;
    logic [31:0] r_t;
    logic [7:0]  r_y;

    logic signed [9:0]  w_a_off;
    logic signed [9:0]  w_b_off;
    logic signed [19:0] w_mac_prod;
    logic [31:0]        w_mul_x;
    logic [31:0]        w_mul_y;
    logic [31:0]        w_mul;
    logic [4:0]         w_shift;
    logic [31:0]        w_rbias;
    logic [31:0]        w_sra;
    logic signed [31:0] w_lo;
    logic signed [31:0] w_hi;
    logic signed [31:0] w_ts;
    logic [7:0]         w_clamped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha     <= ALPHA_RST;
            r_beta      <= '0;
            r_c_zp      <= '0;
            r_shift_rnd <= '0;
            r_a_zp      <= '0;
            r_b_zp      <= '0;
            r_y_zp      <= '0;
            r_clamp     <= CLAMP_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ALPHA: r_alpha     <= i_cfg_data;
                CFG_BETA:  r_beta      <= i_cfg_data;
                CFG_C_ZP:  r_c_zp      <= i_cfg_data;
                CFG_SHIFT: r_shift_rnd <= i_cfg_data[5:0];
                CFG_A_ZP:  r_a_zp      <= i_cfg_data[8:0];
                CFG_B_ZP:  r_b_zp      <= i_cfg_data[8:0];
                CFG_Y_ZP:  r_y_zp      <= i_cfg_data;
                CFG_CLAMP: r_clamp     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // offset operands fit in 10 bits, their product in 20
    assign w_a_off    = 10'(i_a_elem) + 10'($signed(r_a_zp));
    assign w_b_off    = 10'(i_b_elem) + 10'($signed(r_b_zp));
    assign w_mac_prod = w_a_off * w_b_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_cmd.mac) begin
            r_acc <= r_acc + 32'(w_mac_prod);
        end else if (i_cmd.step == STEP_BETA) begin
            r_acc <= '0;
        end
    end

    // shared 32x32 multiplier, low word only
    always_comb begin
        case (i_cmd.step)
            STEP_ALPHA: begin
                w_mul_x = r_alpha;
                w_mul_y = r_acc;
            end
            STEP_BETA: begin
                w_mul_x = r_beta;
                w_mul_y = r_csum;
            end
            default: begin
                w_mul_x = r_t;
                w_mul_y = r_rq_mul;
            end
        endcase
    end
    assign w_mul = w_mul_x * w_mul_y;

    assign w_shift   = r_shift_rnd[4:0];
    assign w_rbias   = (r_shift_rnd[5] && (w_shift != 5'd0)) ?
                       (32'd1 << (w_shift - 5'd1)) : 32'd0;
    assign w_sra     = 32'($signed(r_t) >>> w_shift);
    assign w_lo      = 32'($signed(r_clamp[7:0]));
    assign w_hi      = 32'($signed(r_clamp[15:8]));
    assign w_ts      = $signed(r_t);
    assign w_clamped = (w_ts < w_lo) ? w_lo[7:0] :
                       (w_ts > w_hi) ? w_hi[7:0] : r_t[7:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            // beta*c + beta*cz equals beta*(c + cz) modulo 2^32
            r_csum   <= i_c_elem + r_c_zp;
            r_rq_mul <= i_requant_mul;
            r_rq_add <= i_requant_add;
        end
        case (i_cmd.step)
            STEP_ALPHA: r_prod <= w_mul;
            STEP_BETA: begin
                r_t    <= r_prod;
                r_prod <= w_mul;
            end
            STEP_SUM:   r_t    <= r_t + r_prod;
            STEP_RQ:    r_prod <= w_mul;
            STEP_BIAS:  r_t    <= r_prod + w_rbias + r_rq_add;
            STEP_SHIFT: r_t    <= w_sra + r_y_zp;
            STEP_OUT:   r_y    <= w_clamped;
            default: ;
        endcase
    end

    assign o_y_elem = r_y;

endmodule

### src/int8_dot_product_requantizer.sv
// int8 dot product with requantization, one output element per run of pairs
// throughput: pairs without last_pair are taken one per cycle; the last pair
//   closes the input through the ALPHA, BETA, SUM, RQ, BIAS, SHIFT and OUT
//   states, the single shared 32x32 multiplier working alpha, beta and the
//   requant factor in turn; the result word loads in OUT once the slot is free
// reset: synchronous active low, config regs to defaults, accumulator cleared
module int8_dot_product_requantizer import idpr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input word channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic signed [7:0]     i_a_elem,
    input  logic signed [7:0]     i_b_elem,
    input  logic signed [31:0]    i_c_elem,
    input  logic signed [31:0]    i_requant_mul,
    input  logic signed [31:0]    i_requant_add,
    input  logic                  i_last_pair,
    // output word channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic signed [7:0]     o_y_elem
);

    t_dp_cmd w_cmd;

    // sequencer: accepts pairs, then steps the requant chain
    idpr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_pair (i_last_pair),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    // mac, config registers, shared multiplier, shift and clamp
    idpr_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (w_cmd),
        .i_a_elem      (i_a_elem),
        .i_b_elem      (i_b_elem),
        .i_c_elem      (i_c_elem),
        .i_requant_mul (i_requant_mul),
        .i_requant_add (i_requant_add),
        .o_y_elem      (o_y_elem)
    );

    // a last pair starts the requant chain, which blocks the input
    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_last_pair) |=> !o_in_ready)
        else $error("input still open after last pair");

    // ordinary pairs stream without a bubble
    a_mac_streams: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !i_last_pair) |=> o_in_ready)
        else $error("input closed after ordinary pair");

    // reset leaves the block open and empty
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_in_ready && !o_out_valid))
        else $error("bad state after reset");

endmodule

### dv/tb.sv
`timescale 1ns / 100ps

module tb import idpr_pkg::*; ();

    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 4;
    localparam int MAX_IDLE       = 18;
    localparam int N_PHASES       = 8;
    localparam int PHASE_WORDS    = 100;
    localparam int MAX_RUN        = 16;
    localparam int WATCHDOG_LIMIT = 2000;

    // one input word as it sits in the stimulus queue
    typedef struct {
        logic signed [7:0] a;
        logic signed [7:0] b;
        logic [31:0]       c;
        logic [31:0]       rm;
        logic [31:0]       ra;
        logic              last;
    } t_pair_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic signed [7:0]     i_a_elem = '0;
    logic signed [7:0]     i_b_elem = '0;
    logic signed [31:0]    i_c_elem = '0;
    logic signed [31:0]    i_requant_mul = '0;
    logic signed [31:0]    i_requant_add = '0;
    logic                  i_last_pair = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic signed [7:0]     o_y_elem;

    // stimulus, expected words and handshake bookkeeping
    t_pair_word        pend_q[$];
    logic signed [7:0] exp_q[$];
    t_pair_word        drv_word;
    logic signed [7:0] exp_y;
    int                in_gap = 0;
    int                out_gap = 0;
    int                out_draw = 0;
    logic              in_fire_seen = 1'b0;
    logic              out_fire_seen = 1'b0;
    int                n_pushed = 0;
    int                n_in = 0;
    int                n_out = 0;
    int                n_last = 0;
    int                n_err = 0;
    int                idle_cycles = 0;

    // model state
    logic [31:0] m_alpha;
    logic [31:0] m_beta;
    logic [31:0] m_c_zp;
    logic [5:0]  m_shift_rnd;
    logic [8:0]  m_a_zp;
    logic [8:0]  m_b_zp;
    logic [31:0] m_y_zp;
    logic [15:0] m_clamp;
    logic [31:0] m_acc;

    int8_dot_product_requantizer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_a_elem      (i_a_elem),
        .i_b_elem      (i_b_elem),
        .i_c_elem      (i_c_elem),
        .i_requant_mul (i_requant_mul),
        .i_requant_add (i_requant_add),
        .i_last_pair   (i_last_pair),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_y_elem      (o_y_elem)
    );

    function automatic void model_reset();
        m_alpha     = ALPHA_RST;
        m_beta      = '0;
        m_c_zp      = '0;
        m_shift_rnd = '0;
        m_a_zp      = '0;
        m_b_zp      = '0;
        m_y_zp      = '0;
        m_clamp     = CLAMP_RST;
        m_acc       = '0;
    endfunction

    function automatic void model_config(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] val);
        case (t_cfg_idx'(idx))
            CFG_ALPHA: m_alpha     = val;
            CFG_BETA:  m_beta      = val;
            CFG_C_ZP:  m_c_zp      = val;
            CFG_SHIFT: m_shift_rnd = val[5:0];
            CFG_A_ZP:  m_a_zp      = val[8:0];
            CFG_B_ZP:  m_b_zp      = val[8:0];
            CFG_Y_ZP:  m_y_zp      = val;
            CFG_CLAMP: m_clamp     = val[15:0];
            default: ;
        endcase
    endfunction

    // accumulate one pair, and on the last pair push the expected word
    function automatic void model_step(logic signed [7:0] a, logic signed [7:0] b,
                                       logic [31:0] c, logic [31:0] rm,
                                       logic [31:0] ra, logic last);
        logic signed [31:0] a_off;
        logic signed [31:0] b_off;
        logic [4:0]         sh;
        logic [31:0]        rbias;
        logic [31:0]        t;
        logic signed [31:0] y;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        a_off = 32'(a) + 32'($signed(m_a_zp));
        b_off = 32'(b) + 32'($signed(m_b_zp));
        m_acc = m_acc + 32'(a_off * b_off);
        if (last) begin
            sh    = m_shift_rnd[4:0];
            rbias = '0;
            if (m_shift_rnd[5] && (sh != 5'd0)) rbias = 32'd1 << (sh - 5'd1);
            t  = m_alpha * m_acc + m_beta * c + m_beta * m_c_zp;
            t  = t * rm + rbias + ra;
            t  = 32'($signed(t) >>> sh) + m_y_zp;
            y  = $signed(t);
            lo = 32'($signed(m_clamp[7:0]));
            hi = 32'($signed(m_clamp[15:8]));
            if (y < lo) y = lo;
            else if (y > hi) y = hi;
            exp_q.push_back(y[7:0]);
            m_acc = '0;
        end
    endfunction

    // mix of full range, small, extreme and moderate values
    function automatic logic [31:0] spread_word();
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = 32'($urandom_range(0, 32)) - 32'd16;
            2: v = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: v = 32'($urandom_range(0, 131071)) - 32'd65536;
        endcase
        return v;
    endfunction

    task automatic cfg_write(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    task automatic random_config();
        cfg_write(CFG_ALPHA, spread_word());
        cfg_write(CFG_BETA, spread_word());
        cfg_write(CFG_C_ZP, spread_word());
        cfg_write(CFG_SHIFT, $urandom);
        cfg_write(CFG_A_ZP, $urandom);
        cfg_write(CFG_B_ZP, $urandom);
        cfg_write(CFG_Y_ZP, spread_word());
        if ($urandom_range(0, 1) != 0) cfg_write(CFG_CLAMP, 32'(CLAMP_RST));
        else cfg_write(CFG_CLAMP, $urandom);
    endtask

    // queue runs of pairs, each run closed by a last pair
    task automatic push_phase(int n_words);
        int         made;
        int         run_len;
        t_pair_word w;
        made = 0;
        while (made < n_words) begin
            run_len = $urandom_range(1, MAX_RUN);
            if (run_len > n_words - made) run_len = n_words - made;
            for (int k = 0; k < run_len; k++) begin
                w.a    = 8'($urandom);
                w.b    = 8'($urandom);
                w.c    = spread_word();
                w.rm   = spread_word();
                w.ra   = spread_word();
                w.last = (k == run_len - 1);
                pend_q.push_back(w);
                n_pushed++;
            end
            made += run_len;
        end
    endtask

    // every queued word taken and every expected word seen
    task automatic wait_drain();
        while (n_in != n_pushed || exp_q.size() != 0) @(negedge i_clk);
    endtask

    always #(CLK_HALF) i_clk = ~i_clk;

    // input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap     <= 0;
        end else if (!i_in_valid || in_fire_seen) begin
            if (in_gap != 0) begin
                in_gap     <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (pend_q.size() != 0) begin
                drv_word       = pend_q.pop_front();
                i_a_elem      <= drv_word.a;
                i_b_elem      <= drv_word.b;
                i_c_elem      <= drv_word.c;
                i_requant_mul <= drv_word.rm;
                i_requant_add <= drv_word.ra;
                i_last_pair   <= drv_word.last;
                i_in_valid    <= 1'b1;
                in_gap        <= $urandom_range(0, MAX_IDLE);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output side idling
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_gap     <= $urandom_range(0, MAX_IDLE);
        end else if (out_fire_seen) begin
            out_draw     = $urandom_range(0, MAX_IDLE);
            out_gap     <= out_draw;
            i_out_ready <= (out_draw == 0);
        end else if (out_gap != 0) begin
            out_gap     <= out_gap - 1;
            i_out_ready <= (out_gap == 1);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // monitor, predictor and watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            model_reset();
            in_fire_seen  <= 1'b0;
            out_fire_seen <= 1'b0;
            idle_cycles    = 0;
        end else begin
            in_fire_seen  <= i_in_valid && o_in_ready;
            out_fire_seen <= o_out_valid && i_out_ready;
            if (o_out_valid && i_out_ready) begin
                n_out++;
                if (exp_q.size() == 0) begin
                    $error("y_elem: expected no word, actual %0d", o_y_elem);
                    n_err++;
                end else begin
                    exp_y = exp_q.pop_front();
                    if (o_y_elem !== exp_y) begin
                        $error("y_elem: expected %0d, actual %0d", exp_y, o_y_elem);
                        n_err++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                n_in++;
                if (i_last_pair) n_last++;
                model_step(i_a_elem, i_b_elem, i_c_elem, i_requant_mul,
                           i_requant_add, i_last_pair);
            end
            if (i_cfg_we) model_config(i_cfg_idx, i_cfg_data);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", idle_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
        for (int p = 0; p < N_PHASES; p++) begin
            if (p == 1) begin
                // rounding enabled with a zero shift
                cfg_write(CFG_SHIFT, 32'h0000_0020);
                cfg_write(CFG_ALPHA, 32'($urandom_range(0, 7)));
            end else if (p > 1) begin
                random_config();
            end
            push_phase(PHASE_WORDS);
            wait_drain();
        end
        repeat (20) @(negedge i_clk);
        $display("run: %0d pair words in %0d dot products over %0d register sets",
                 n_in, n_last, N_PHASES);
        $display("run: %0d result words checked under random stalls, %0d mismatches",
                 n_out, n_err);
        if (n_err == 0 && n_out == n_last && exp_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### int8_dot_product_requantizer.f
src/idpr_pkg.sv
src/idpr_ctrl.sv
src/idpr_datapath.sv
src/int8_dot_product_requantizer.sv
dv/tb.sv
